// ===== rtl/core/scbs_pkg.sv =====
// Shared types and constants for the scanline cycle budget scheduler.
// No dependencies; imported by every module of the block.
package scbs_pkg;

   localparam int CPL_W      = 24;
   localparam int LINE_W     = 10;
   localparam int TSTATE_W   = 16;
   localparam int GRANT_W    = 16;
   localparam int FRAC_W     = 16;
   localparam int DEBT_W     = 24;
   localparam int FRAME_W    = 32;
   localparam int TOTAL_W    = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int RSP_DATA_W = 152;

   localparam logic ACTION_STEP   = 1'b0;
   localparam logic ACTION_REPORT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_CPL      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_LPF      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_LAST_VIS = 2'd2;

   localparam logic [CPL_W-1:0]  CPL_RESET      = 24'd14927135;
   localparam logic [LINE_W-1:0] LPF_RESET      = 10'd262;
   localparam logic [LINE_W-1:0] LAST_VIS_RESET = 10'd191;
   localparam logic [DEBT_W-1:0] DEBT_MAX       = 24'hFFFFFF;

   typedef struct packed {
      logic [CPL_W-1:0]  cycles_per_line_q16;
      logic [LINE_W-1:0] lines_per_frame;
      logic [LINE_W-1:0] last_visible_line;
   } cfg_type;

   typedef struct packed {
      logic                action;
      logic [TSTATE_W-1:0] tstates;
   } req_item_type;

   typedef struct packed {
      logic [GRANT_W-1:0] cycles_granted;
      logic [LINE_W-1:0]  scanline;
      logic               visible;
      logic [FRAME_W-1:0] frame_count;
      logic [DEBT_W-1:0]  debt;
      logic [TOTAL_W-1:0] total_tstates;
   } rsp_item_type;

endpackage

// ===== rtl/core/scbs_in_reg.sv =====
// Input register stage: captures one request and holds it until the engine takes it.
// Depends on scbs_pkg.
module scbs_in_reg
   import scbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  req_item_type req_item,
   input  logic         take,
   output logic         in_valid,
   output req_item_type in_item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign req_tready = !valid_ff || take;
   assign load       = req_tvalid && req_tready;
   assign in_valid   = valid_ff;
   assign in_item    = item_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== rtl/core/scbs_engine.sv =====
// Budget engine: scheduler state, the per-request update and the result register.
// Depends on scbs_pkg.
module scbs_engine
   import scbs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   input  req_item_type in_item,
   output logic         take,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic [FRAC_W-1:0]  acc_fraction_ff, acc_fraction_in;
   logic [DEBT_W-1:0]  cycle_debt_ff, cycle_debt_in;
   logic [GRANT_W-1:0] last_grant_ff, last_grant_in;
   logic [LINE_W-1:0]  current_line_ff, current_line_in;
   logic [FRAME_W-1:0] frames_done_ff, frames_done_in;
   logic [TOTAL_W-1:0] tstate_total_ff, tstate_total_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;

   logic [CPL_W:0]        acc;
   logic [8:0]            grant_raw;
   logic [8:0]            grant_net;
   logic                  grant_covers;
   logic [DEBT_W-1:0]     debt_after_step;
   logic [LINE_W-1:0]     line_inc;
   logic                  line_wrap;
   logic                  overshoot;
   logic [TSTATE_W-1:0]   over_amt;
   logic [DEBT_W:0]       debt_sum;
   logic [DEBT_W-1:0]     debt_after_report;
   logic [LINE_W-1:0]     shown_line;

   assign take      = in_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   always_comb begin
      // Q16 accumulate; integer part is at most 256
      acc          = {{(CPL_W+1-FRAC_W){1'b0}}, acc_fraction_ff}
                     + {1'b0, cfg.cycles_per_line_q16};
      grant_raw    = acc[CPL_W:FRAC_W];
      // zero debt comes out of either branch unchanged
      grant_covers = {{(DEBT_W-9){1'b0}}, grant_raw} > cycle_debt_ff;
      if (grant_covers) begin
         grant_net       = grant_raw - cycle_debt_ff[8:0];
         debt_after_step = '0;
      end else begin
         grant_net       = 9'd0;
         debt_after_step = cycle_debt_ff - {{(DEBT_W-9){1'b0}}, grant_raw};
      end

      line_inc  = current_line_ff + 10'd1;
      line_wrap = (line_inc >= cfg.lines_per_frame) || (line_inc == '0);

      overshoot = in_item.tstates > last_grant_ff;
      over_amt  = in_item.tstates - last_grant_ff;
      debt_sum  = {1'b0, cycle_debt_ff} + {{(DEBT_W+1-TSTATE_W){1'b0}}, over_amt};
      debt_after_report = debt_sum[DEBT_W] ? DEBT_MAX : debt_sum[DEBT_W-1:0];

      acc_fraction_in = acc_fraction_ff;
      cycle_debt_in   = cycle_debt_ff;
      last_grant_in   = last_grant_ff;
      current_line_in = current_line_ff;
      frames_done_in  = frames_done_ff;
      tstate_total_in = tstate_total_ff;
      shown_line      = current_line_ff;

      if (in_item.action == ACTION_STEP) begin
         acc_fraction_in = acc[FRAC_W-1:0];
         cycle_debt_in   = debt_after_step;
         last_grant_in   = {{(GRANT_W-9){1'b0}}, grant_net};
         if (line_wrap) begin
            current_line_in = '0;
            frames_done_in  = frames_done_ff + 32'd1;
         end else begin
            current_line_in = line_inc;
         end
      end else begin
         tstate_total_in = tstate_total_ff + {{(TOTAL_W-TSTATE_W){1'b0}}, in_item.tstates};
         if (overshoot) begin
            cycle_debt_in = debt_after_report;
         end
      end

      rsp_item_in.cycles_granted = last_grant_in;
      rsp_item_in.scanline       = shown_line;
      rsp_item_in.visible        = shown_line <= cfg.last_visible_line;
      rsp_item_in.frame_count    = frames_done_in;
      rsp_item_in.debt           = cycle_debt_in;
      rsp_item_in.total_tstates  = tstate_total_in;

      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_fraction_ff <= '0;
         cycle_debt_ff   <= '0;
         last_grant_ff   <= '0;
         current_line_ff <= '0;
         frames_done_ff  <= '0;
         tstate_total_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            acc_fraction_ff <= acc_fraction_in;
            cycle_debt_ff   <= cycle_debt_in;
            last_grant_ff   <= last_grant_in;
            current_line_ff <= current_line_in;
            frames_done_ff  <= frames_done_in;
            tstate_total_ff <= tstate_total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

endmodule

// ===== rtl/core/scanline_cycle_budget_scheduler.sv =====
// Top level of the scanline cycle budget scheduler: config registers and stream ports.
// Depends on scbs_pkg, scbs_in_reg and scbs_engine.
//
// Usage:
//  - req channel: tuser is the action (step one scanline or report executed
//    T-states), tdata carries the T-state count, used on reports only.
//  - rsp channel: one status result per request, see the rsp_tdata layout.
//  - csr port: write-only; index 0 cycles per line (unsigned Q8.16),
//    1 lines per frame, 2 last visible line. Other indexes are dropped.
//    Write only while no request is in flight.
//  - Registers: an accepted request passes the input register, then the
//    result register, before its result shows.
//  - Throughput: one request per cycle while rsp_tready stays high; the engine
//    does its state update (accumulate, debt repay, line advance) per request.
//  - Reset clears all scheduler state and restores config defaults
//    (14927135, 262, 191); no result is pending after reset.
//  - When rsp_tready is low the result holds; the input register still
//    takes one more request, after which req_tready drops.
module scanline_cycle_budget_scheduler
   import scbs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [TSTATE_W-1:0]   req_tdata,   // [15:0] tstates
   input  logic                  req_tuser,   // [0] action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [15:0] cycles_granted, [25:16] scanline, [26] visible, [58:27] frame_count,
   // [82:59] debt, [146:83] total_tstates, [151:147] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg_ff;
   cfg_type      cfg_in;
   req_item_type req_item;
   req_item_type in_item;
   rsp_item_type rsp_item;
   logic         in_valid;
   logic         take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_IDX_CPL:      cfg_in.cycles_per_line_q16 = csr_wdata[CPL_W-1:0];
            CSR_IDX_LPF:      cfg_in.lines_per_frame     = csr_wdata[LINE_W-1:0];
            CSR_IDX_LAST_VIS: cfg_in.last_visible_line   = csr_wdata[LINE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cycles_per_line_q16 <= CPL_RESET;
         cfg_ff.lines_per_frame     <= LPF_RESET;
         cfg_ff.last_visible_line   <= LAST_VIS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item.action  = req_tuser;
   assign req_item.tstates = req_tdata;

   scbs_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .in_valid   (in_valid),
      .in_item    (in_item)
   );

   scbs_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (in_valid),
      .in_item   (in_item),
      .take      (take),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = {5'd0,
                       rsp_item.total_tstates,
                       rsp_item.debt,
                       rsp_item.frame_count,
                       rsp_item.visible,
                       rsp_item.scanline,
                       rsp_item.cycles_granted};

endmodule

// ===== rtl/core/scbs_checker.sv =====
// Port-level checks for the scanline cycle budget scheduler, bound to the top level.
// Depends on scbs_pkg and scanline_cycle_budget_scheduler.
module scbs_checker
   import scbs_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // nothing pending right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // with the result slot empty, the input side can always take a request
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty result slot");

   // the line counter wraps before it can reach all ones
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[25:16] != 10'h3FF)
      else $error("scanline out of range");

endmodule

bind scanline_cycle_budget_scheduler scbs_checker u_scbs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== dv/testbench.sv =====
// Testbench for the scanline cycle budget scheduler: directed and random step/report
// requests, checked against an in-bench model of the budget, debt and frame counters.
// Depends on scbs_pkg and the scanline_cycle_budget_scheduler RTL.
module testbench;
   import scbs_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_UNUSED = 2'd3;
   localparam int STALL_CYCLES = 300;

   typedef struct {
      logic [GRANT_W-1:0] grant;
      logic [LINE_W-1:0]  line;
      logic               vis;
      logic [FRAME_W-1:0] frames;
      logic [DEBT_W-1:0]  debt;
      logic [TOTAL_W-1:0] total;
   } line_status_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TSTATE_W-1:0]   req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   always #5 clock = ~clock;

   scanline_cycle_budget_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // budget model: config copy and scheduler state
   logic [CPL_W-1:0]   mdl_cpl = CPL_RESET;
   logic [LINE_W-1:0]  mdl_lpf = LPF_RESET;
   logic [LINE_W-1:0]  mdl_vis = LAST_VIS_RESET;
   logic [FRAC_W-1:0]  mdl_frac = '0;
   logic [DEBT_W-1:0]  mdl_debt = '0;
   logic [GRANT_W-1:0] mdl_last_grant = '0;
   logic [LINE_W-1:0]  mdl_line = '0;
   logic [FRAME_W-1:0] mdl_frames = '0;
   logic [TOTAL_W-1:0] mdl_total = '0;

   req_item_type    req_pending[$];
   line_status_type expected_status[$];
   req_item_type    req_cur;

   int send_idle_pct = 27;
   int recv_idle_pct = 27;
   int stall_requests = 0;
   int stall_served = 0;
   int stall_left = 0;
   int fail_count = 0;
   int n_steps = 0;
   int n_reports = 0;
   int n_results = 0;
   int n_wraps = 0;
   int n_saturations = 0;
   int n_csr_writes = 0;

   function automatic void predict_status(input req_item_type rq);
      logic [CPL_W:0]     acc;
      logic [DEBT_W:0]    sum;
      logic [GRANT_W-1:0] grant;
      logic [LINE_W-1:0]  shown;
      line_status_type    st;
      if (rq.action == ACTION_STEP) begin
         n_steps++;
         acc = {1'b0, mdl_cpl} + {{(CPL_W+1-FRAC_W){1'b0}}, mdl_frac};
         grant = GRANT_W'(acc[CPL_W:FRAC_W]);
         mdl_frac = acc[FRAC_W-1:0];
         if (mdl_debt != '0) begin
            if (DEBT_W'(grant) > mdl_debt) begin
               grant = grant - GRANT_W'(mdl_debt);
               mdl_debt = '0;
            end else begin
               mdl_debt = mdl_debt - DEBT_W'(grant);
               grant = '0;
            end
         end
         mdl_last_grant = grant;
         shown = mdl_line;
         mdl_line = mdl_line + 1'b1;
         if (mdl_line >= mdl_lpf || mdl_line == '0) begin
            mdl_line = '0;
            mdl_frames = mdl_frames + 1'b1;
            n_wraps++;
         end
      end else begin
         n_reports++;
         mdl_total = mdl_total + TOTAL_W'(rq.tstates);
         if (rq.tstates > mdl_last_grant) begin
            sum = {1'b0, mdl_debt} + (DEBT_W+1)'(rq.tstates - mdl_last_grant);
            if (sum > {1'b0, DEBT_MAX}) begin
               mdl_debt = DEBT_MAX;
               n_saturations++;
            end else begin
               mdl_debt = sum[DEBT_W-1:0];
            end
         end
         shown = mdl_line;
      end
      st.grant  = mdl_last_grant;
      st.line   = shown;
      st.vis    = (shown <= mdl_vis);
      st.frames = mdl_frames;
      st.debt   = mdl_debt;
      st.total  = mdl_total;
      expected_status.push_back(st);
   endfunction

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // request driver
   always @(posedge clock) begin : req_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            predict_status(req_cur);
         if (!req_tvalid || req_tready) begin
            if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_cur = req_pending.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= req_cur.tstates;
               req_tuser  <= req_cur.action;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // status monitor, with random and long hold-offs on rsp_tready
   always @(posedge clock) begin : rsp_monitor
      line_status_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_results++;
            if (expected_status.size() == 0) begin
               $display("%0t: unexpected status, expected none, actual 0x%0h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               want = expected_status.pop_front();
               check_field("cycles_granted", 64'(want.grant), 64'(rsp_tdata[15:0]));
               check_field("scanline", 64'(want.line), 64'(rsp_tdata[25:16]));
               check_field("visible", 64'(want.vis), 64'(rsp_tdata[26]));
               check_field("frame_count", 64'(want.frames), 64'(rsp_tdata[58:27]));
               check_field("debt", 64'(want.debt), 64'(rsp_tdata[82:59]));
               check_field("total_tstates", want.total, rsp_tdata[146:83]);
               check_field("pad", 64'd0, 64'(rsp_tdata[151:147]));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (stall_served != stall_requests) begin
            stall_served++;
            stall_left = STALL_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic push_req(input logic action, input logic [TSTATE_W-1:0] ts);
      req_item_type rq;
      rq.action  = action;
      rq.tstates = ts;
      req_pending.push_back(rq);
   endtask

   task automatic wait_drained();
      while (req_pending.size() != 0 || req_tvalid || expected_status.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      n_csr_writes++;
      case (idx)
         CSR_IDX_CPL:      mdl_cpl = data;
         CSR_IDX_LPF:      mdl_lpf = data[LINE_W-1:0];
         CSR_IDX_LAST_VIS: mdl_vis = data[LINE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // upper bits of the line registers carry junk, which must be dropped
   task automatic set_config(input logic [CPL_W-1:0] cpl, input logic [LINE_W-1:0] lpf,
                             input logic [LINE_W-1:0] vis);
      wait_drained();
      write_csr(CSR_IDX_CPL, cpl);
      write_csr(CSR_IDX_LPF, {(CSR_DATA_W-LINE_W)'($urandom), lpf});
      write_csr(CSR_IDX_LAST_VIS, {(CSR_DATA_W-LINE_W)'($urandom), vis});
   endtask

   task automatic random_config();
      logic [CPL_W-1:0]  cpl;
      logic [LINE_W-1:0] lpf;
      logic [LINE_W-1:0] vis;
      case ($urandom_range(3))
         0: cpl = 24'h010000;
         1: cpl = 24'hFFFFFF;
         2: cpl = CPL_W'($urandom_range(24'hFFFFFF, 24'h010000));
         default: cpl = CPL_W'($urandom_range(24'h00FFFF));
      endcase
      case ($urandom_range(3))
         0: lpf = 10'd2;
         1: lpf = 10'd1023;
         2: lpf = LINE_W'($urandom_range(8, 2));
         default: lpf = LINE_W'($urandom);
      endcase
      case ($urandom_range(3))
         0: vis = 10'd0;
         1: vis = 10'd1022;
         2: vis = LINE_W'($urandom);
         default: vis = 10'd1023;
      endcase
      set_config(cpl, lpf, vis);
   endtask

   // report sizes track the current grant so debt mostly drains again
   task automatic random_phase(input int count, input int report_pct, input int big_pct);
      int unsigned hint;
      int unsigned pick;
      hint = int'(mdl_cpl >> FRAC_W);
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if ($urandom_range(99) >= report_pct)
            push_req(ACTION_STEP, TSTATE_W'($urandom));
         else if (pick < 6)
            push_req(ACTION_REPORT, '0);
         else if (pick < 6 + big_pct)
            push_req(ACTION_REPORT, pick[0] ? 16'hFFFF : TSTATE_W'($urandom));
         else
            push_req(ACTION_REPORT, TSTATE_W'($urandom_range(hint + 4)));
      end
   endtask

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset defaults: plain grants, zero report, large overshoot
      push_req(ACTION_STEP, 16'hFFFF);
      push_req(ACTION_STEP, '0);
      push_req(ACTION_REPORT, '0);
      push_req(ACTION_REPORT, 16'hFFFF);
      push_req(ACTION_STEP, '0);

      // one cycle per line: debt equal to grant, then debt above grant
      set_config(24'h010000, 10'd2, 10'd0);
      push_req(ACTION_STEP, '0);
      push_req(ACTION_REPORT, 16'd2);
      push_req(ACTION_STEP, '0);
      push_req(ACTION_REPORT, 16'd5);
      push_req(ACTION_STEP, '0);
      push_req(ACTION_STEP, '0);
      push_req(ACTION_REPORT, '0);

      // largest rate, zero-length frame, visible limit out of range, bad index
      set_config(24'hFFFFFF, 10'd0, 10'd1023);
      write_csr(CSR_IDX_UNUSED, CSR_DATA_W'($urandom));
      push_req(ACTION_STEP, '0);
      push_req(ACTION_STEP, '0);
      push_req(ACTION_REPORT, 16'hFFFF);
      push_req(ACTION_STEP, '0);
      wait_drained();
      write_csr(CSR_IDX_LPF, 24'd1);
      push_req(ACTION_STEP, '0);
      push_req(ACTION_STEP, '0);

      // frame shortened below the current line
      set_config(CPL_RESET, 10'd1023, 10'd1022);
      repeat (6) push_req(ACTION_STEP, '0);
      wait_drained();
      write_csr(CSR_IDX_LPF, 24'd3);
      push_req(ACTION_STEP, '0);
      push_req(ACTION_STEP, '0);

      for (int p = 0; p < 8; p++) begin
         random_config();
         send_idle_pct = (p == 2) ? 0 : 27;
         recv_idle_pct = (p == 2) ? 0 : 27;
         if (p == 7)
            random_phase(420, 95, 94);   // drives debt into saturation
         else
            random_phase(204, (p % 2 == 0) ? 45 : 20, 3);
         if (p == 1)
            stall_requests++;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      $display("Run covered %0d steps, %0d reports, %0d status results, %0d frame wraps.",
               n_steps, n_reports, n_results, n_wraps);
      $display("%0d register writes, %0d debt saturations, %0d long output stalls.",
               n_csr_writes, n_saturations, stall_served);
      if (fail_count == 0 && expected_status.size() == 0)
         $display("** scanline_cycle_budget_scheduler: PASSED **");
      else
         $display("** scanline_cycle_budget_scheduler: FAILED **");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("timeout: %0d status results still expected", expected_status.size());
      $display("** scanline_cycle_budget_scheduler: FAILED **");
      $finish;
   end

endmodule
